// ===== rtl/cld_pkg.sv =====
// Shared types and constants of the capability list deframer.
package cld_pkg;

  localparam int UINTVAR_MAX_OCTETS = 5;
  localparam int LEN_W = 7 * UINTVAR_MAX_OCTETS;
  localparam int CNT_W = $clog2(UINTVAR_MAX_OCTETS + 1);

  localparam logic [7:0] CAP_INDEX_MAX = 8'hff;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_FIRST,
    PH_NAME,
    PH_DATA,
    PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_LENGTH     = 3'd0,
    ROLE_SHORT_ID   = 3'd1,
    ROLE_NAME       = 3'd2,
    ROLE_TERMINATOR = 3'd3,
    ROLE_DATA       = 3'd4,
    ROLE_DISCARD    = 3'd5
  } role_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] octet_out;
    role_t      role;
    logic [7:0] cap_index;
    logic [6:0] short_id;
    logic       is_named;
    logic       record_end;
    logic       frame_end;
    logic       error;
  } result_t;

  // Handshake between the input register and the parser.
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } stage_t;

endpackage

// ===== rtl/cld_in_if.sv =====
// Octet channel carrying the packed capability list.
interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       frame_last;

  modport source (output valid, output octet, output frame_last, input ready);
  modport sink (input valid, input octet, input frame_last, output ready);
endinterface

// ===== rtl/cld_out_if.sv =====
// Labelled octet channel produced by the deframer.
interface cld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet_out;
  logic [2:0] role;
  logic [7:0] cap_index;
  logic [6:0] short_id;
  logic       is_named;
  logic       record_end;
  logic       frame_end;
  logic       error;

  modport source (output valid, output octet_out, output role, output cap_index,
                  output short_id, output is_named, output record_end,
                  output frame_end, output error, input ready);
  modport sink (input valid, input octet_out, input role, input cap_index,
                input short_id, input is_named, input record_end,
                input frame_end, input error, output ready);
endinterface

// ===== rtl/cld_in_stage.sv =====
// Input register: captures one octet beat and holds it until the parser takes it.
module cld_in_stage (
  input  logic            clk,
  input  logic            rst,
  cld_in_if.sink          octet_stream,
  input  logic            take,
  output cld_pkg::stage_t stage
);

  logic               valid;
  cld_pkg::in_beat_t  beat;
  logic               load;

  assign octet_stream.ready = !valid || take;
  assign load = octet_stream.valid && octet_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat.octet      <= octet_stream.octet;
      beat.frame_last <= octet_stream.frame_last;
    end
  end

  assign stage.valid = valid;
  assign stage.beat  = beat;

endmodule

// ===== rtl/cld_parser.sv =====
// Record parser: per-octet role decode and frame state update.
module cld_parser (
  input  logic              clk,
  input  logic              rst,
  input  cld_pkg::stage_t   stage,
  input  logic              advance,
  output cld_pkg::result_t  result
);

  cld_pkg::phase_t                phase, phase_next;
  logic [cld_pkg::LEN_W-1:0]      length_accum, length_accum_next;
  logic [cld_pkg::CNT_W-1:0]      uintvar_octets, uintvar_octets_next;
  logic [cld_pkg::LEN_W-1:0]      body_remaining, body_remaining_next;
  logic [7:0]                     record_count, record_count_next;
  logic [6:0]                     current_id, current_id_next;
  logic                           named_flag, named_flag_next;

  logic [7:0]                     o;
  logic                           last;
  logic [cld_pkg::CNT_W-1:0]      uv_inc;
  logic [cld_pkg::LEN_W-1:0]      accum_shift;
  logic [cld_pkg::LEN_W-1:0]      body_dec;
  logic                           body_done;

  cld_pkg::role_t                 role;
  logic [6:0]                     sid;
  logic                           nm;
  logic                           rend;
  logic                           err;
  cld_pkg::phase_t                phase_go;

  assign o           = stage.beat.octet;
  assign last        = stage.beat.frame_last;
  assign uv_inc      = uintvar_octets + cld_pkg::CNT_W'(1);
  assign accum_shift = {length_accum[cld_pkg::LEN_W-8:0], o[6:0]};
  assign body_dec    = body_remaining - cld_pkg::LEN_W'(1);
  assign body_done   = (body_dec == '0) || last;

  // Decode the octet against the current phase.
  always_comb begin
    role     = cld_pkg::ROLE_DISCARD;
    sid      = '0;
    nm       = 1'b0;
    rend     = 1'b0;
    err      = 1'b0;
    phase_go = phase;
    case (phase)
      cld_pkg::PH_LEN: begin
        role = cld_pkg::ROLE_LENGTH;
        if (o[7]) begin
          err = (uv_inc >= cld_pkg::CNT_W'(cld_pkg::UINTVAR_MAX_OCTETS)) || last;
        end else if ((accum_shift == '0) || last) begin
          err = 1'b1;
        end else begin
          phase_go = cld_pkg::PH_FIRST;
        end
      end
      cld_pkg::PH_FIRST, cld_pkg::PH_NAME: begin
        if (phase == cld_pkg::PH_FIRST && o[7]) begin
          role = cld_pkg::ROLE_SHORT_ID;
          sid  = o[6:0];
          nm   = 1'b0;
          if (body_done) begin
            rend = 1'b1;
          end else begin
            phase_go = cld_pkg::PH_DATA;
          end
        end else begin
          // A first octet below 0x80 opens a name.
          sid = (phase == cld_pkg::PH_FIRST) ? 7'd0 : current_id;
          nm  = (phase == cld_pkg::PH_FIRST) ? 1'b1 : named_flag;
          if (o == 8'd0) begin
            role = cld_pkg::ROLE_TERMINATOR;
            if (body_done) begin
              rend = 1'b1;
            end else begin
              phase_go = cld_pkg::PH_DATA;
            end
          end else begin
            role = cld_pkg::ROLE_NAME;
            if (body_done) begin
              err = 1'b1;
            end else begin
              phase_go = cld_pkg::PH_NAME;
            end
          end
        end
      end
      cld_pkg::PH_DATA: begin
        role = cld_pkg::ROLE_DATA;
        sid  = current_id;
        nm   = named_flag;
        rend = body_done;
      end
      default: begin
        role = cld_pkg::ROLE_DISCARD;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next          = phase_go;
    length_accum_next   = length_accum;
    uintvar_octets_next = uintvar_octets;
    body_remaining_next = body_remaining;
    record_count_next   = record_count;
    current_id_next     = current_id;
    named_flag_next     = named_flag;
    case (phase)
      cld_pkg::PH_LEN: begin
        uintvar_octets_next = uv_inc;
        length_accum_next   = accum_shift;
        if (phase_go == cld_pkg::PH_FIRST) begin
          body_remaining_next = accum_shift;
        end
      end
      cld_pkg::PH_FIRST: begin
        body_remaining_next = body_dec;
        current_id_next     = sid;
        named_flag_next     = nm;
      end
      cld_pkg::PH_NAME, cld_pkg::PH_DATA: begin
        body_remaining_next = body_dec;
      end
      default: begin
      end
    endcase
    if (rend) begin
      if (record_count != cld_pkg::CAP_INDEX_MAX) begin
        record_count_next = record_count + 8'd1;
      end
      phase_next          = cld_pkg::PH_LEN;
      length_accum_next   = '0;
      uintvar_octets_next = '0;
      body_remaining_next = '0;
    end
    if (err) begin
      phase_next = cld_pkg::PH_DISCARD;
    end
    // Frame end: start the next octet from a clean state.
    if (last) begin
      phase_next          = cld_pkg::PH_LEN;
      length_accum_next   = '0;
      uintvar_octets_next = '0;
      body_remaining_next = '0;
      record_count_next   = '0;
      current_id_next     = '0;
      named_flag_next     = 1'b0;
    end
  end

  // Result fields.
  always_comb begin
    result.octet_out  = o;
    result.role       = role;
    result.cap_index  = record_count;
    result.short_id   = sid;
    result.is_named   = nm;
    result.record_end = rend;
    result.frame_end  = last;
    result.error      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cld_pkg::PH_LEN;
      length_accum   <= '0;
      uintvar_octets <= '0;
      body_remaining <= '0;
      record_count   <= '0;
      current_id     <= '0;
      named_flag     <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      length_accum   <= length_accum_next;
      uintvar_octets <= uintvar_octets_next;
      body_remaining <= body_remaining_next;
      record_count   <= record_count_next;
      current_id     <= current_id_next;
      named_flag     <= named_flag_next;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> phase == cld_pkg::PH_LEN && record_count == 8'd0)
    else $error("state not cleared after frame end");

  a_error_discards: assert property (@(posedge clk) disable iff (rst)
    advance && err && !last |=> phase == cld_pkg::PH_DISCARD)
    else $error("error did not enter discard");

  a_discard_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && phase == cld_pkg::PH_DISCARD |->
      role == cld_pkg::ROLE_DISCARD && !err && !rend)
    else $error("discarded octet labelled wrongly");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    advance && !last |=> record_count >= $past(record_count))
    else $error("record count went backwards inside a frame");

  // An over-long length leaves the count at the limit while the frame is discarded.
  a_uintvar_bound: assert property (@(posedge clk) disable iff (rst)
    uintvar_octets <= cld_pkg::CNT_W'(cld_pkg::UINTVAR_MAX_OCTETS))
    else $error("length octet count out of range");

endmodule

// ===== rtl/cld_out_stage.sv =====
// Result register: holds one labelled octet until the sink takes it.
module cld_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  cld_pkg::result_t result,
  input  logic             load,
  output logic             room,
  cld_out_if.source        label_stream
);

  logic             valid;
  cld_pkg::result_t res;

  assign room = !valid || label_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (label_stream.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= result;
    end
  end

  assign label_stream.valid      = valid;
  assign label_stream.octet_out  = res.octet_out;
  assign label_stream.role       = res.role;
  assign label_stream.cap_index  = res.cap_index;
  assign label_stream.short_id   = res.short_id;
  assign label_stream.is_named   = res.is_named;
  assign label_stream.record_end = res.record_end;
  assign label_stream.frame_end  = res.frame_end;
  assign label_stream.error      = res.error;

endmodule

// ===== rtl/capability_list_deframer_core.sv =====
// Capability list deframer: labels each octet of a length-prefixed record list.
// Each accepted octet beat is held in the input register, then its labelled result
// in the result register, from which label_stream accepts it.
// Throughput: one octet per cycle while label_stream is ready; an input register
// and a result register decouple the channels; parser state updates once per octet.
// Reset (rst, synchronous): empties both registers and returns the parser to the
// start of a frame.
module capability_list_deframer_core (
  input  logic      clk,
  input  logic      rst,
  cld_in_if.sink    octet_stream,
  cld_out_if.source label_stream
);

  cld_pkg::stage_t  stage;
  cld_pkg::result_t result;
  logic             room;
  logic             advance;

  assign advance = stage.valid && room;

  cld_in_stage u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .octet_stream (octet_stream),
    .take         (advance),
    .stage        (stage)
  );

  cld_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

  cld_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .load         (advance),
    .room         (room),
    .label_stream (label_stream)
  );

endmodule

// ===== test/capability_list_deframer_core_tb.sv =====
// Self-checking testbench for the capability list deframer core.
module capability_list_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octets_t [$];

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_OCTETS = 40;

  // Tracks the parser state and holds the labels still owed by the core.
  class cap_scoreboard;
    cld_pkg::phase_t           phase;
    logic [cld_pkg::LEN_W-1:0] accum;
    int unsigned               len_octets;
    logic [cld_pkg::LEN_W-1:0] remaining;
    logic [7:0]                rec_count;
    logic [6:0]                cur_id;
    logic                      cur_named;
    cld_pkg::result_t          label_q[$];
    int unsigned               errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase = cld_pkg::PH_LEN;
      accum = '0;
      len_octets = 0;
      remaining = '0;
      rec_count = '0;
      cur_id = '0;
      cur_named = 1'b0;
    endfunction

    // Name octet or terminator; remaining has already been counted down.
    function void name_step(logic [7:0] o, logic last, output cld_pkg::role_t role,
                            inout logic rend, inout logic err);
      if (o == 8'h00) begin
        role = cld_pkg::ROLE_TERMINATOR;
        if (remaining == 0 || last) rend = 1'b1;
        else phase = cld_pkg::PH_DATA;
      end else begin
        role = cld_pkg::ROLE_NAME;
        if (remaining == 0 || last) err = 1'b1;
        else phase = cld_pkg::PH_NAME;
      end
    endfunction

    function void note_octet(logic [7:0] o, logic last);
      cld_pkg::result_t r;
      logic             rend;
      logic             err;
      r = '0;
      r.octet_out = o;
      r.cap_index = rec_count;
      r.frame_end = last;
      r.role = cld_pkg::ROLE_LENGTH;
      rend = 1'b0;
      err = 1'b0;
      case (phase)
        cld_pkg::PH_LEN: begin
          len_octets++;
          accum = {accum[cld_pkg::LEN_W-8:0], o[6:0]};
          if (o[7]) begin
            if (len_octets >= cld_pkg::UINTVAR_MAX_OCTETS || last) err = 1'b1;
          end else if (accum == 0 || last) begin
            err = 1'b1;
          end else begin
            remaining = accum;
            phase = cld_pkg::PH_FIRST;
          end
        end
        cld_pkg::PH_FIRST: begin
          remaining = remaining - 1'b1;
          if (o[7]) begin
            cur_id = o[6:0];
            cur_named = 1'b0;
            r.role = cld_pkg::ROLE_SHORT_ID;
            if (remaining == 0 || last) rend = 1'b1;
            else phase = cld_pkg::PH_DATA;
          end else begin
            cur_id = '0;
            cur_named = 1'b1;
            name_step(o, last, r.role, rend, err);
          end
          r.short_id = cur_id;
          r.is_named = cur_named;
        end
        cld_pkg::PH_NAME: begin
          remaining = remaining - 1'b1;
          name_step(o, last, r.role, rend, err);
          r.short_id = cur_id;
          r.is_named = cur_named;
        end
        cld_pkg::PH_DATA: begin
          remaining = remaining - 1'b1;
          r.role = cld_pkg::ROLE_DATA;
          if (remaining == 0 || last) rend = 1'b1;
          r.short_id = cur_id;
          r.is_named = cur_named;
        end
        default: r.role = cld_pkg::ROLE_DISCARD;
      endcase
      if (rend) begin
        if (rec_count != cld_pkg::CAP_INDEX_MAX) rec_count++;
        phase = cld_pkg::PH_LEN;
        accum = '0;
        len_octets = 0;
        remaining = '0;
      end
      if (err) phase = cld_pkg::PH_DISCARD;
      if (last) clear();
      r.record_end = rend;
      r.error = err;
      label_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_label(cld_pkg::result_t got);
      cld_pkg::result_t exp;
      if (label_q.size() == 0) begin
        $error("label beat with no octet outstanding: octet_out=%0h", got.octet_out);
        errors++;
        return;
      end
      exp = label_q.pop_front();
      compare_field("octet_out", exp.octet_out, got.octet_out);
      compare_field("role", 8'(exp.role), 8'(got.role));
      compare_field("cap_index", exp.cap_index, got.cap_index);
      compare_field("short_id", 8'(exp.short_id), 8'(got.short_id));
      compare_field("is_named", 8'(exp.is_named), 8'(got.is_named));
      compare_field("record_end", 8'(exp.record_end), 8'(got.record_end));
      compare_field("frame_end", 8'(exp.frame_end), 8'(got.frame_end));
      compare_field("error", 8'(exp.error), 8'(got.error));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  cap_scoreboard sb = new();

  cld_in_if  octet_ch ();
  cld_out_if label_ch ();

  capability_list_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .octet_stream (octet_ch),
    .label_stream (label_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    label_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      cld_pkg::result_t got;
      if (octet_ch.valid && octet_ch.ready) sb.note_octet(octet_ch.octet, octet_ch.frame_last);
      if (label_ch.valid && label_ch.ready) begin
        got.octet_out = label_ch.octet_out;
        got.role = cld_pkg::role_t'(label_ch.role);
        got.cap_index = label_ch.cap_index;
        got.short_id = label_ch.short_id;
        got.is_named = label_ch.is_named;
        got.record_end = label_ch.record_end;
        got.frame_end = label_ch.frame_end;
        got.error = label_ch.error;
        sb.check_label(got);
      end
    end
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (octet_ch.valid && octet_ch.ready) || (label_ch.valid && label_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_octet(logic [7:0] o, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      octet_ch.valid <= 1'b0;
      @(posedge clk);
    end
    octet_ch.valid <= 1'b1;
    octet_ch.octet <= o;
    octet_ch.frame_last <= last;
    @(posedge clk);
    while (!octet_ch.ready) @(posedge clk);
  endtask

  task automatic drive_frame(input octets_t f);
    foreach (f[i]) send_octet(f[i], i == f.size() - 1);
  endtask

  // Uintvar length, optionally padded with empty leading groups.
  function automatic void add_length(ref octets_t f, input logic [cld_pkg::LEN_W-1:0] len,
                                     input int pad);
    int groups = 1;
    while (groups < cld_pkg::UINTVAR_MAX_OCTETS && (len >> (7 * groups)) != 0) groups++;
    if (pad > cld_pkg::UINTVAR_MAX_OCTETS - groups) pad = cld_pkg::UINTVAR_MAX_OCTETS - groups;
    repeat (pad) f.push_back(8'h80);
    for (int g = groups - 1; g >= 0; g--) f.push_back({g != 0, len[7 * g +: 7]});
  endfunction

  // Length plus the first keep octets of the body.
  function automatic void add_record(ref octets_t f, input logic [cld_pkg::LEN_W-1:0] len,
                                     input int keep, input bit named, input int name_len,
                                     input int pad);
    logic [7:0] b;
    add_length(f, len, pad);
    for (int i = 0; i < keep; i++) begin
      if (!named) b = (i == 0) ? {1'b1, 7'($urandom)} : 8'($urandom);
      else if (i < name_len) b = (i == 0) ? 8'($urandom_range(1, 127))
                                          : 8'($urandom_range(1, 255));
      else if (i == name_len) b = 8'h00;
      else b = 8'($urandom);
      f.push_back(b);
    end
  endfunction

  function automatic void add_good_record(ref octets_t f);
    logic [cld_pkg::LEN_W-1:0] len;
    int pick = int'($urandom_range(0, 99));
    bit named = 1'($urandom_range(0, 1));
    int pad = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 4)) : 0;
    if (pick < 80) len = cld_pkg::LEN_W'($urandom_range(1, 8));
    else if (pick < 95) len = cld_pkg::LEN_W'($urandom_range(9, 140));
    else len = cld_pkg::LEN_W'($urandom_range(141, 300));
    add_record(f, len, int'(len), named, int'($urandom_range(0, int'(len) - 1)), pad);
  endfunction

  function automatic void build_frame(ref octets_t f);
    logic [cld_pkg::LEN_W-1:0] len;
    int n_rec = int'($urandom_range(0, 3));
    int pick = int'($urandom_range(0, 99));
    int kind;
    int span;
    int name_len;
    bit named;
    repeat (n_rec) add_good_record(f);
    if (pick < 60) begin
      add_good_record(f);
    end else if (pick < 72) begin
      // cut the last record after its name, somewhere in the data
      named = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) len = cld_pkg::LEN_W'($urandom_range(2, 20));
      else len = {3'($urandom), 32'($urandom)} | 35'd2;
      span = (len > 40) ? 40 : int'(len);
      name_len = named ? int'($urandom_range(0, (span - 2 < 6) ? span - 2 : 6)) : 0;
      add_record(f, len,
                 int'($urandom_range(name_len + 1, (span - 1 < name_len + 8) ? span - 1
                                                                             : name_len + 8)),
                 named, name_len, int'($urandom_range(0, 1)));
    end else begin
      kind = int'($urandom_range(0, 6));
      case (kind)
        0: add_length(f, '0, int'($urandom_range(0, 4)));
        1: repeat (cld_pkg::UINTVAR_MAX_OCTETS) f.push_back({1'b1, 7'($urandom)});
        2: repeat ($urandom_range(1, 4)) f.push_back({1'b1, 7'($urandom)});
        3: add_length(f, cld_pkg::LEN_W'($urandom_range(1, 300)), 0);
        4: begin
          len = cld_pkg::LEN_W'($urandom_range(1, 8));
          add_record(f, len, int'(len), 1'b1, int'(len), 0);
        end
        5: begin
          len = cld_pkg::LEN_W'($urandom_range(2, 10));
          add_record(f, len, int'($urandom_range(1, int'(len) - 1)), 1'b1, int'(len) - 1, 0);
        end
        default: repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
      endcase
      // trailing octets after an error get discarded
      if (kind inside {0, 1, 4}) repeat ($urandom_range(0, 4)) f.push_back(8'($urandom));
    end
  endfunction

  task automatic run_random(int n_octets);
    octets_t f;
    int sent = 0;
    while (sent < n_octets) begin
      f.delete();
      build_frame(f);
      drive_frame(f);
      sent += f.size();
    end
  endtask

  initial begin
    octets_t f;
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    octet_ch.valid = 1'b0;
    octet_ch.octet = '0;
    octet_ch.frame_last = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // short ids 0 and 127, empty name, data, cut after a terminator
    drive_frame('{8'h01, 8'h80, 8'h01, 8'h00, 8'h02, 8'hff, 8'h00, 8'h05, 8'h7f, 8'h00});
    drive_frame('{8'h00, 8'hff});                        // zero length, then discard
    drive_frame('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80});   // over-long length
    drive_frame('{8'h81});                               // frame ends inside the length
    drive_frame('{8'h05});                               // length complete, no body
    drive_frame('{8'h02, 8'h41, 8'h42});                 // terminator missing
    drive_frame('{8'h03, 8'h41});                        // frame ends inside the name
    drive_frame('{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h85}); // largest length, truncated

    // enough one-octet records to saturate the record index
    repeat (257) begin
      f.push_back(8'h01);
      f.push_back({1'b1, 7'($urandom)});
    end
    drive_frame(f);

    run_random(RANDOM_OCTETS);
    idle_pct = 67;
    run_random(RANDOM_OCTETS);
    idle_pct = 0;
    stall_pct = 67;
    run_random(RANDOM_OCTETS);
    idle_pct = 8;
    stall_pct = 8;
    run_random(RANDOM_OCTETS);

    octet_ch.valid <= 1'b0;
    while (sb.label_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
